FILE: hdl/gbfr_pkg.sv
`default_nettype none

package gbfr_pkg;

    localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2 = 8'h62;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DATA     = 3'd1,
        EV_HANDLED  = 3'd2,
        EV_IGNORED  = 3'd3,
        EV_CKERR    = 3'd4,
        EV_LENERR   = 3'd5,
        EV_DISABLED = 3'd6
    } t_event;

    // frame parser phase, one-hot
    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN1    = 9'b000010000,
        PH_LEN2    = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK1     = 9'b010000000,
        PH_CK2     = 9'b100000000
    } t_phase;

    // configuration register indexes
    localparam logic REG_RECEIVER_CONFIGURED = 1'b0;
    localparam logic REG_USE_PVT_MODE        = 1'b1;

    // message keys {class, id}
    localparam logic [15:0] MSG_NAV_PVT     = 16'h0107;
    localparam logic [15:0] MSG_NAV_POSLLH  = 16'h0102;
    localparam logic [15:0] MSG_NAV_SOL     = 16'h0106;
    localparam logic [15:0] MSG_NAV_TIMEUTC = 16'h0121;
    localparam logic [15:0] MSG_NAV_VELNED  = 16'h0112;
    localparam logic [15:0] MSG_NAV_DOP     = 16'h0104;
    localparam logic [15:0] MSG_NAV_SVINFO  = 16'h0130;
    localparam logic [15:0] MSG_MON_VER     = 16'h0A04;
    localparam logic [15:0] MSG_MON_HW      = 16'h0A09;
    localparam logic [15:0] MSG_ACK_ACK     = 16'h0501;
    localparam logic [15:0] MSG_ACK_NAK     = 16'h0500;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
        logic        will_handle;
    } t_result;

    typedef struct packed {
        t_event ev;      // EV_NONE when the frame goes on
        logic   handle;
    } t_verdict;

    // acceptance table applied once the length is complete
    function automatic t_verdict f_accept(
        input logic [7:0]  cls,
        input logic [7:0]  id,
        input logic [15:0] len,
        input logic        cfg,
        input logic        pvt
    );
        t_verdict    v;
        logic [15:0] size1;
        logic [15:0] size2;
        logic        check_len;
        logic        ign;
        logic        dis;
        logic        known;
        size1     = 16'd0;
        size2     = 16'd0;
        check_len = 1'b1;
        ign       = !cfg;
        dis       = 1'b0;
        known     = 1'b1;
        case ({cls, id})
            MSG_NAV_PVT: begin
                size1 = 16'd84; size2 = 16'd92; dis = !pvt;
            end
            MSG_NAV_POSLLH: begin
                size1 = 16'd28; size2 = 16'd28; dis = pvt;
            end
            MSG_NAV_SOL: begin
                size1 = 16'd52; size2 = 16'd52; dis = pvt;
            end
            MSG_NAV_TIMEUTC: begin
                size1 = 16'd20; size2 = 16'd20; dis = pvt;
            end
            MSG_NAV_VELNED: begin
                size1 = 16'd36; size2 = 16'd36; dis = pvt;
            end
            MSG_NAV_DOP: begin
                size1 = 16'd18; size2 = 16'd18;
            end
            MSG_NAV_SVINFO: begin
                check_len = 1'b0;
            end
            MSG_MON_VER: begin
                check_len = 1'b0; ign = 1'b0;
            end
            MSG_MON_HW: begin
                size1 = 16'd68; size2 = 16'd60;
            end
            MSG_ACK_ACK, MSG_ACK_NAK: begin
                size1 = 16'd2; size2 = 16'd2; ign = cfg;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        v.handle = 1'b0;
        if (!known) begin
            v.ev = EV_DISABLED;
        end else if (check_len && len != size1 && len != size2) begin
            v.ev = EV_LENERR;
        end else if (ign) begin
            v.ev = EV_NONE;
        end else if (dis) begin
            v.ev = EV_DISABLED;
        end else begin
            v.ev     = EV_NONE;
            v.handle = 1'b1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gnss_binary_frame_receiver.sv
// gnss binary frame receiver
//
// input channel: one received serial byte per transfer on i_rx_byte
// (i_in_valid / o_in_stall). output channel: exactly one result per input
// byte (o_out_valid / i_out_stall) carrying the event code, the payload
// byte and its index, and the class, id, declared length and disposition
// of the current frame.
// the result of a byte is registered. throughput: one byte per cycle while
// o_in_stall is low; the frame state update is a single pass of logic ahead
// of the result register, so every cycle without a stall can take a byte.
// when the receiver stalls, the result register holds and one more result
// lands in a skid register; o_in_stall then rises (it is a register output)
// until the downstream side takes the held result.
// configuration: an apb-style port, receiver_configured at 0x0 and
// use_pvt_mode at 0x4, bit 0; write only while the block is idle.
// reset (i_rst_n low at a clock edge): the parser hunts for the first sync
// byte, checksums, class, id, length and position are cleared, disposition
// is set to handle, both registers read 0 and both result slots are empty.
`default_nettype none

module gnss_binary_frame_receiver
    import gbfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,

    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_data_byte,
    output logic [15:0]      o_byte_index,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_id,
    output logic [15:0]      o_payload_len,
    output logic             o_will_handle,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic r_cfg_configured;
    logic r_cfg_pvt_mode;

    // frame state
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_sum_a,      n_sum_a;
    logic [7:0]  r_sum_b,      n_sum_b;
    logic [7:0]  r_cur_class,  n_cur_class;
    logic [7:0]  r_cur_id,     n_cur_id;
    logic [15:0] r_cur_length, n_cur_length;
    logic [15:0] r_payload_pos, n_payload_pos;
    logic        r_handle,     n_handle;

    // result register and skid stage
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic     in_xfer;
    logic     out_take;
    logic     cfg_write;
    t_verdict verdict;
    logic [7:0]  sum_a_add;
    logic [15:0] len_full;
    logic        done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {31'd0, (paddr[2] == REG_USE_PVT_MODE) ? r_cfg_pvt_mode
                                                              : r_cfg_configured};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_configured <= 1'b0;
            r_cfg_pvt_mode   <= 1'b0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_RECEIVER_CONFIGURED) begin
                r_cfg_configured <= pwdata[0];
            end else begin
                r_cfg_pvt_mode <= pwdata[0];
            end
        end
    end

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    // running fletcher sum a including this byte, and the full length word
    assign sum_a_add = r_sum_a + i_rx_byte;
    assign len_full  = {i_rx_byte, r_cur_length[7:0]};
    assign verdict   = f_accept(r_cur_class, r_cur_id, len_full,
                                r_cfg_configured, r_cfg_pvt_mode);

    // per-byte frame update
    always_comb begin
        n_phase       = r_phase;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_cur_class   = r_cur_class;
        n_cur_id      = r_cur_id;
        n_cur_length  = r_cur_length;
        n_payload_pos = r_payload_pos;
        n_handle      = r_handle;
        done          = 1'b0;
        n_result.event_res  = EV_NONE;
        n_result.data_byte  = 8'd0;
        n_result.byte_index = 16'd0;

        case (r_phase)
            PH_SYNC2: begin
                n_phase = (i_rx_byte == SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                n_sum_a     = sum_a_add;
                n_sum_b     = r_sum_b + sum_a_add;
                n_cur_class = i_rx_byte;
                n_phase     = PH_ID;
            end
            PH_ID: begin
                n_sum_a  = sum_a_add;
                n_sum_b  = r_sum_b + sum_a_add;
                n_cur_id = i_rx_byte;
                n_phase  = PH_LEN1;
            end
            PH_LEN1: begin
                n_sum_a      = sum_a_add;
                n_sum_b      = r_sum_b + sum_a_add;
                n_cur_length = {8'd0, i_rx_byte};
                n_phase      = PH_LEN2;
            end
            PH_LEN2: begin
                n_sum_a      = sum_a_add;
                n_sum_b      = r_sum_b + sum_a_add;
                n_cur_length = len_full;
                n_handle     = verdict.handle;
                n_result.event_res = verdict.ev;
                if (verdict.ev != EV_NONE) begin
                    done = 1'b1;
                end else begin
                    n_phase = (len_full != 16'd0) ? PH_PAYLOAD : PH_CK1;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
                n_result.event_res  = EV_DATA;
                n_result.data_byte  = i_rx_byte;
                n_result.byte_index = r_payload_pos;
                // last payload byte when pos + 1 >= length
                if ({1'b0, r_payload_pos} + 17'd1 >= {1'b0, r_cur_length}) begin
                    n_phase = PH_CK1;
                end
                n_payload_pos = r_payload_pos + 16'd1;
            end
            PH_CK1: begin
                if (i_rx_byte != r_sum_a) begin
                    n_result.event_res = EV_CKERR;
                    done = 1'b1;
                end else begin
                    n_phase = PH_CK2;
                end
            end
            PH_CK2: begin
                if (i_rx_byte != r_sum_b) begin
                    n_result.event_res = EV_CKERR;
                end else begin
                    n_result.event_res = r_handle ? EV_HANDLED : EV_IGNORED;
                end
                done = 1'b1;
            end
            default: begin
                // hunt for the first sync byte, also out of any stray code
                n_phase = (i_rx_byte == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase

        // frame identity reported before the end-of-frame clear
        n_result.msg_class   = n_cur_class;
        n_result.msg_id      = n_cur_id;
        n_result.payload_len = n_cur_length;
        n_result.will_handle = n_handle;

        if (done) begin
            n_phase       = PH_SYNC1;
            n_sum_a       = 8'd0;
            n_sum_b       = 8'd0;
            n_cur_length  = 16'd0;
            n_payload_pos = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC1;
            r_sum_a       <= 8'd0;
            r_sum_b       <= 8'd0;
            r_cur_class   <= 8'd0;
            r_cur_id      <= 8'd0;
            r_cur_length  <= 16'd0;
            r_payload_pos <= 16'd0;
            r_handle      <= 1'b1;
        end else if (in_xfer) begin
            r_phase       <= n_phase;
            r_sum_a       <= n_sum_a;
            r_sum_b       <= n_sum_b;
            r_cur_class   <= n_cur_class;
            r_cur_id      <= n_cur_id;
            r_cur_length  <= n_cur_length;
            r_payload_pos <= n_payload_pos;
            r_handle      <= n_handle;
        end
    end

    // output slot and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_result;
            end
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_data_byte   = r_out.data_byte;
    assign o_byte_index  = r_out.byte_index;
    assign o_msg_class   = r_out.msg_class;
    assign o_msg_id      = r_out.msg_id;
    assign o_payload_len = r_out.payload_len;
    assign o_will_handle = r_out.will_handle;

`ifndef SYNTH
    // the skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    // a payload byte index always lies inside the declared length
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_DATA)
            |-> (r_out.byte_index < r_out.payload_len))
        else $error("payload index beyond declared length");

    // every accepted byte leaves the result register valid in the cycle after it
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted byte produced no result");

    // sums restart at zero whenever the hunt for sync begins
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SYNC1) |-> (r_sum_a == 8'd0 && r_sum_b == 8'd0))
        else $error("checksum not cleared while hunting for sync");
`endif

endmodule

`default_nettype wire

FILE: bench/gbfr_result_checker.sv
module gbfr_result_checker
    import gbfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_rx_byte,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_event_res,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_byte_index,
    input  wire logic [7:0]  i_msg_class,
    input  wire logic [7:0]  i_msg_id,
    input  wire logic [15:0] i_payload_len,
    input  wire logic        i_will_handle,

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,

    output int               o_mismatches,
    output int               o_pending
);

    // shadow of the parser state
    t_phase      parse_phase;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  cur_class;
    logic [7:0]  cur_id;
    logic [15:0] cur_len;
    logic [15:0] pay_pos;
    logic        handle_frame;

    // shadow of the configuration registers
    logic        cfg_configured;
    logic        cfg_pvt_mode;

    t_result     expected_results[$];
    int          mismatch_total;
    int          results_seen;

    function automatic void fold_into_sums(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic void clear_frame();
        parse_phase = PH_SYNC1;
        sum_a       = 8'd0;
        sum_b       = 8'd0;
        cur_len     = 16'd0;
        pay_pos     = 16'd0;
    endfunction

    // acceptance table: sets the disposition, gives an abort event or none
    function automatic t_event judge_frame();
        logic size_ok;
        logic skipped;
        logic blocked;
        size_ok = 1'b0;
        skipped = !cfg_configured;
        blocked = 1'b0;
        case ({cur_class, cur_id})
            MSG_NAV_PVT: begin
                size_ok = (cur_len == 16'd84) || (cur_len == 16'd92);
                blocked = !cfg_pvt_mode;
            end
            MSG_NAV_POSLLH: begin
                size_ok = cur_len == 16'd28;
                blocked = cfg_pvt_mode;
            end
            MSG_NAV_SOL: begin
                size_ok = cur_len == 16'd52;
                blocked = cfg_pvt_mode;
            end
            MSG_NAV_TIMEUTC: begin
                size_ok = cur_len == 16'd20;
                blocked = cfg_pvt_mode;
            end
            MSG_NAV_VELNED: begin
                size_ok = cur_len == 16'd36;
                blocked = cfg_pvt_mode;
            end
            MSG_NAV_DOP: begin
                size_ok = cur_len == 16'd18;
            end
            MSG_NAV_SVINFO: begin
                size_ok = 1'b1;
            end
            MSG_MON_VER: begin
                size_ok = 1'b1;
                skipped = 1'b0;
            end
            MSG_MON_HW: begin
                size_ok = (cur_len == 16'd68) || (cur_len == 16'd60);
            end
            MSG_ACK_ACK, MSG_ACK_NAK: begin
                size_ok = cur_len == 16'd2;
                skipped = cfg_configured;
            end
            default: begin
                handle_frame = 1'b0;
                return EV_DISABLED;
            end
        endcase
        handle_frame = size_ok && !skipped && !blocked;
        if (!size_ok)
            return EV_LENERR;
        if (!skipped && blocked)
            return EV_DISABLED;
        return EV_NONE;
    endfunction

    // advance the parser by one byte and give the result it should report
    function automatic t_result parse_byte(input logic [7:0] c);
        t_result     r;
        logic        finished;
        logic [15:0] len_seen;
        r           = '0;
        r.event_res = EV_NONE;
        finished    = 1'b0;
        case (parse_phase)
            PH_SYNC2: begin
                parse_phase = (c == SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                fold_into_sums(c);
                cur_class   = c;
                parse_phase = PH_ID;
            end
            PH_ID: begin
                fold_into_sums(c);
                cur_id      = c;
                parse_phase = PH_LEN1;
            end
            PH_LEN1: begin
                fold_into_sums(c);
                cur_len     = {8'h00, c};
                parse_phase = PH_LEN2;
            end
            PH_LEN2: begin
                fold_into_sums(c);
                cur_len[15:8] = c;
                r.event_res   = judge_frame();
                if (r.event_res != EV_NONE)
                    finished = 1'b1;
                else
                    parse_phase = (cur_len != 16'd0) ? PH_PAYLOAD : PH_CK1;
            end
            PH_PAYLOAD: begin
                fold_into_sums(c);
                r.event_res  = EV_DATA;
                r.data_byte  = c;
                r.byte_index = pay_pos;
                // widened so that a full 64k payload still ends
                if ({1'b0, pay_pos} + 17'd1 >= {1'b0, cur_len})
                    parse_phase = PH_CK1;
                pay_pos = pay_pos + 16'd1;
            end
            PH_CK1: begin
                if (c != sum_a) begin
                    r.event_res = EV_CKERR;
                    finished    = 1'b1;
                end else begin
                    parse_phase = PH_CK2;
                end
            end
            PH_CK2: begin
                if (c != sum_b)
                    r.event_res = EV_CKERR;
                else
                    r.event_res = handle_frame ? EV_HANDLED : EV_IGNORED;
                finished = 1'b1;
            end
            default: begin
                parse_phase = (c == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
        len_seen = cur_len;
        if (finished)
            clear_frame();
        r.msg_class   = cur_class;
        r.msg_id      = cur_id;
        r.payload_len = len_seen;
        r.will_handle = handle_frame;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        if (mismatch_total < 10)
            $display("result %0d: %s", results_seen, what);
        mismatch_total++;
    endfunction

    initial begin
        mismatch_total = 0;
        results_seen   = 0;
        o_mismatches   = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_frame();
            cur_class      = 8'd0;
            cur_id         = 8'd0;
            handle_frame   = 1'b1;
            cfg_configured = 1'b0;
            cfg_pvt_mode   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_USE_PVT_MODE)
                    cfg_pvt_mode = i_pwdata[0];
                else
                    cfg_configured = i_pwdata[0];
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(parse_byte(i_rx_byte));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result, event %0d", i_event_res));
                end else begin
                    want = expected_results.pop_front();
                    if (i_event_res !== want.event_res)
                        note_failure($sformatf("event expected %0d, got %0d",
                                               want.event_res, i_event_res));
                    if (i_data_byte !== want.data_byte)
                        note_failure($sformatf("data byte expected %0h, got %0h",
                                               want.data_byte, i_data_byte));
                    if (i_byte_index !== want.byte_index)
                        note_failure($sformatf("byte index expected %0d, got %0d",
                                               want.byte_index, i_byte_index));
                    if (i_msg_class !== want.msg_class)
                        note_failure($sformatf("class expected %0h, got %0h",
                                               want.msg_class, i_msg_class));
                    if (i_msg_id !== want.msg_id)
                        note_failure($sformatf("id expected %0h, got %0h",
                                               want.msg_id, i_msg_id));
                    if (i_payload_len !== want.payload_len)
                        note_failure($sformatf("length expected %0d, got %0d",
                                               want.payload_len, i_payload_len));
                    if (i_will_handle !== want.will_handle)
                        note_failure($sformatf("handle flag expected %0b, got %0b",
                                               want.will_handle, i_will_handle));
                end
                results_seen++;
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: bench/tb_gnss_binary_frame_receiver.sv
module tb_gnss_binary_frame_receiver;
    import gbfr_pkg::*;

    // how a frame's checksum pair is spoilt
    localparam int CK_GOOD  = 0;
    localparam int CK_BAD_A = 1;
    localparam int CK_BAD_B = 2;

    localparam logic [15:0] KNOWN_KEYS [11] = '{
        MSG_NAV_PVT, MSG_NAV_POSLLH, MSG_NAV_SOL, MSG_NAV_TIMEUTC, MSG_NAV_VELNED,
        MSG_NAV_DOP, MSG_NAV_SVINFO, MSG_MON_VER, MSG_MON_HW, MSG_ACK_ACK, MSG_ACK_NAK
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_event_res;
    logic [7:0]  o_data_byte;
    logic [15:0] o_byte_index;
    logic [7:0]  o_msg_class;
    logic [7:0]  o_msg_id;
    logic [15:0] o_payload_len;
    logic        o_will_handle;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // pacing knobs shared by the byte source and the result sink
    int send_idle_pct;
    int recv_idle_pct;
    int holdoff_left;
    int bytes_sent;

    // verdict inputs from the checker
    int mismatches;
    int pending;

    gnss_binary_frame_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_res   (o_event_res),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_msg_class   (o_msg_class),
        .o_msg_id      (o_msg_id),
        .o_payload_len (o_payload_len),
        .o_will_handle (o_will_handle),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // watches both channels and the register port, predicts and compares
    gbfr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_event_res   (o_event_res),
        .i_data_byte   (o_data_byte),
        .i_byte_index  (o_byte_index),
        .i_msg_class   (o_msg_class),
        .i_msg_id      (o_msg_id),
        .i_payload_len (o_payload_len),
        .i_will_handle (o_will_handle),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 12 unit period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result sink: random stalls, or a counted hold-off when one is asked for
    initial begin : result_sink
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                i_out_stall  <= 1'b1;
                holdoff_left = holdoff_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // generous upper bound on the whole run
    initial begin : watchdog
        #(12 * 1_500_000);
        $display("Mismatches found");
        $finish;
    end

    // one byte transfer; idle gaps are decided before the byte is offered,
    // so valid never reacts to the stall
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // sync pair, header, body of random bytes and the checksum pair;
    // body may be shorter than len where the frame is meant to be refused
    task automatic send_frame(input logic [15:0] key, input logic [15:0] len,
                              input int body, input int fault);
        logic [7:0] head [4];
        logic [7:0] run_a;
        logic [7:0] run_b;
        logic [7:0] b;
        head[0] = key[15:8];
        head[1] = key[7:0];
        head[2] = len[7:0];
        head[3] = len[15:8];
        run_a   = 8'd0;
        run_b   = 8'd0;
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_2);
        for (int k = 0; k < 4 + body; k++) begin
            b     = (k < 4) ? head[k] : 8'($urandom);
            run_a = run_a + b;
            run_b = run_b + run_a;
            send_byte(b);
        end
        send_byte((fault == CK_BAD_A) ? run_a ^ 8'($urandom_range(1, 255)) : run_a);
        send_byte((fault == CK_BAD_B) ? run_b ^ 8'($urandom_range(1, 255)) : run_b);
    endtask

    // setup cycle then access cycle; upper data bits are junk on purpose
    task automatic write_reg(input logic index, input logic value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= {31'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering bytes and wait until every predicted result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, some refused sizes,
    // spoilt checksums, line noise and broken sync pairs
    task automatic run_traffic(input int budget);
        int          start;
        int          pick;
        int          fault;
        logic [15:0] key;
        logic [15:0] len;
        logic [7:0]  b;
        logic        any_size;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 14) begin
                b = 8'($urandom);
                if (b == SYNC_CHAR_2)
                    b = ~b;
                send_byte(SYNC_CHAR_1);
                send_byte(b);
            end else begin
                key      = ($urandom_range(7) == 0) ? 16'($urandom)
                                                    : KNOWN_KEYS[$urandom_range(10)];
                any_size = (key == MSG_NAV_SVINFO) || (key == MSG_MON_VER);
                case (key)
                    MSG_NAV_PVT:              len = $urandom_range(1) ? 16'd92 : 16'd84;
                    MSG_NAV_POSLLH:           len = 16'd28;
                    MSG_NAV_SOL:              len = 16'd52;
                    MSG_NAV_TIMEUTC:          len = 16'd20;
                    MSG_NAV_VELNED:           len = 16'd36;
                    MSG_NAV_DOP:              len = 16'd18;
                    MSG_MON_HW:               len = $urandom_range(1) ? 16'd68 : 16'd60;
                    MSG_ACK_ACK, MSG_ACK_NAK: len = 16'd2;
                    default:                  len = 16'($urandom_range(0, 12));
                endcase
                // wrong size never for the two messages that take any size, so no long frame
                // is ever left half sent
                if (!any_size && $urandom_range(7) == 0)
                    len = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 100));
                if ($urandom_range(9) < 8)
                    fault = CK_GOOD;
                else
                    fault = $urandom_range(1) ? CK_BAD_A : CK_BAD_B;
                send_frame(key, len, (len > 16'd100) ? 8 : int'(len), fault);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'd0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        holdoff_left  = 0;
        bytes_sent    = 0;
        send_idle_pct = 19;
        recv_idle_pct = 69;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, registers still at their reset values
        send_byte(8'h00);
        send_byte(8'hFF);
        // broken sync: the second sync-one byte does not restart the pair
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_2);
        // empty payload, checksum straight after the length
        send_frame(MSG_MON_VER, 16'd0, 0, CK_GOOD);
        send_frame(MSG_ACK_ACK, 16'd2, 2, CK_GOOD);
        // first checksum byte wrong, then only the second one wrong
        send_frame(MSG_ACK_NAK, 16'd2, 2, CK_BAD_A);
        send_frame(MSG_ACK_ACK, 16'd2, 2, CK_BAD_B);
        // refused size with the high length bits set
        send_frame(MSG_NAV_PVT, 16'hFF00, 0, CK_GOOD);
        // unlisted message
        send_frame(16'hFFFF, 16'd0, 0, CK_GOOD);
        send_frame(MSG_NAV_DOP, 16'd18, 18, CK_GOOD);
        settle();

        write_reg(REG_RECEIVER_CONFIGURED, 1'b1);
        write_reg(REG_USE_PVT_MODE, 1'b1);
        send_frame(MSG_NAV_PVT, 16'd84, 84, CK_GOOD);
        // separate solution message is off in pvt mode, its body is noise
        send_frame(MSG_NAV_SOL, 16'd52, 52, CK_GOOD);
        send_frame(MSG_MON_HW, 16'd60, 60, CK_GOOD);
        settle();

        // random part, sender idles little, sink stalls a lot
        write_reg(REG_USE_PVT_MODE, 1'b0);
        run_traffic(20);
        settle();

        // the other way round
        send_idle_pct = 69;
        recv_idle_pct = 19;
        write_reg(REG_USE_PVT_MODE, 1'b1);
        run_traffic(20);
        settle();

        // no idling; a long hold-off first so the block backs up its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_RECEIVER_CONFIGURED, 1'b0);
        holdoff_left = 40;
        run_traffic(20);
        settle();

        write_reg(REG_USE_PVT_MODE, 1'b0);
        run_traffic(20);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
